// File: design/obn_pkg.sv
// Shared types and constants for the orthonormal basis block.
package obn_pkg;

  localparam int COMP_W = 16;
  localparam int EXTRA_BITS = 8;
  localparam int SQ_IN_W = 48;
  localparam int LEN_W = SQ_IN_W / 2;
  // dividend bits above the quotient field; stays below the divisor
  localparam int DIV_HI_W = LEN_W - 2;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  sel_x;
    logic  degen;
  } obn_tag_t;

endpackage

// File: design/obn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module obn_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [obn_pkg::SQ_IN_W-1:0] in_rad,
  input  obn_pkg::obn_tag_t       in_tag,
  output logic                    out_valid,
  output logic [obn_pkg::LEN_W-1:0] out_root,
  output obn_pkg::obn_tag_t       out_tag
);
  import obn_pkg::*;

  localparam int NS = LEN_W;
  localparam int RW = LEN_W + 3;

  logic             v_r    [NS];
  logic [SQ_IN_W-1:0] rad_r [NS];
  logic [RW-1:0]    rem_r  [NS];
  logic [LEN_W-1:0] root_r [NS];
  obn_tag_t         tag_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic               v_in;
    logic [SQ_IN_W-1:0] rad_in;
    logic [RW-1:0]      rem_in;
    logic [LEN_W-1:0]   root_in;
    obn_tag_t           tag_in;
    logic [RW-1:0]      rem_sh;
    logic [RW-1:0]      trial;
    logic               fit;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], rad_in[SQ_IN_W-1 -: 2]};
    assign trial  = {{(RW-LEN_W-2){1'b0}}, root_in, 2'b01};
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_in << 2;
        rem_r[k]  <= fit ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_in[LEN_W-2:0], fit};
        tag_r[k]  <= tag_in;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

// File: design/obn_div.sv
// Pipelined two-lane restoring divider with a shared divisor.
module obn_div #(
  parameter int QW = 16,
  parameter int DW = 38
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [DW-1:0]             in_num_a,
  input  logic [DW-1:0]             in_num_b,
  input  logic [obn_pkg::LEN_W-1:0] in_den,
  input  obn_pkg::obn_tag_t         in_tag,
  output logic                      out_valid,
  output logic [QW-1:0]             out_quo_a,
  output logic [QW-1:0]             out_quo_b,
  output obn_pkg::obn_tag_t         out_tag
);
  import obn_pkg::*;

  logic             v_r   [QW];
  logic [LEN_W-1:0] den_r [QW];
  obn_tag_t         tag_r [QW];
  logic [LEN_W-1:0] rem_r [QW][2];
  logic [QW-1:0]    lo_r  [QW][2];
  logic [QW-1:0]    q_r   [QW][2];
  logic [DW-1:0]    num_in [2];

  assign num_in[0] = in_num_a;
  assign num_in[1] = in_num_b;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic             v_in;
    logic [LEN_W-1:0] den_in;
    obn_tag_t         tag_in;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        tag_r[k] <= tag_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [LEN_W-1:0] rem_in;
      logic [QW-1:0]    lo_in;
      logic [QW-1:0]    q_in;
      logic [LEN_W:0]   rem_sh;
      logic [LEN_W:0]   diff;
      logic             fit;

      if (k == 0) begin : g_first
        assign rem_in = LEN_W'(num_in[l][DW-1:QW]);
        assign lo_in  = num_in[l][QW-1:0];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1][l];
        assign lo_in  = lo_r[k-1][l];
        assign q_in   = q_r[k-1][l];
      end

      assign rem_sh = {rem_in, lo_in[QW-1]};
      assign diff   = rem_sh - {1'b0, den_in};
      assign fit    = (rem_sh >= {1'b0, den_in});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= fit ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
          lo_r[k][l]  <= lo_in << 1;
          q_r[k][l]   <= {q_in[QW-2:0], fit};
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo_a = q_r[QW-1][0];
  assign out_quo_b = q_r[QW-1][1];
  assign out_tag   = tag_r[QW-1];

endmodule

// File: design/orthonormal_basis_from_normal_unit.sv
// Tangent and bitangent from a fixed-point normal vector.
// Throughput: one item per cycle unless the spare output entry is full; depth set by the
//   24-stage square root and the FRAC_BITS + 2 stage divider.
// A two-entry output buffer lets the pipeline keep moving while one result waits.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
module orthonormal_basis_from_normal_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  obn_pkg::comp_t in_normal_x,
  input  obn_pkg::comp_t in_normal_y,
  input  obn_pkg::comp_t in_normal_z,
  output logic          out_valid,
  input  logic          out_ready,
  output obn_pkg::comp_t out_tangent_x,
  output obn_pkg::comp_t out_tangent_y,
  output obn_pkg::comp_t out_tangent_z,
  output obn_pkg::comp_t out_bitangent_x,
  output obn_pkg::comp_t out_bitangent_y,
  output obn_pkg::comp_t out_bitangent_z,
  output logic          out_degenerate
);
  import obn_pkg::*;

  localparam int QW = FRAC_BITS + 2;
  localparam int DW = QW + DIV_HI_W;

  typedef struct packed {
    comp_t tx;
    comp_t ty;
    comp_t tz;
    comp_t bx;
    comp_t by;
    comp_t bz;
    logic  degen;
  } res_t;

  function automatic comp_t tan_sat(input logic neg, input logic [31:0] q);
    logic [15:0] m;
    m = q[15:0];
    if (neg) begin
      tan_sat = (q >= 32'd32768) ? comp_t'(16'h8000) : comp_t'(~m + 16'd1);
    end else begin
      tan_sat = (q >= 32'd32767) ? comp_t'(16'h7fff) : comp_t'(m);
    end
  endfunction

  function automatic comp_t rnd_sat(input logic signed [32:0] v);
    logic [32:0] m;
    logic [33:0] r;
    logic [33:0] q;
    m = v[32] ? (~v + 33'd1) : v;
    r = {1'b0, m} + (34'd1 << (FRAC_BITS - 1));
    q = r >> FRAC_BITS;
    if (v[32]) begin
      rnd_sat = (q >= 34'd32768) ? comp_t'(16'h8000) : comp_t'(~q[15:0] + 16'd1);
    end else begin
      rnd_sat = (q >= 34'd32767) ? comp_t'(16'h7fff) : comp_t'(q[15:0]);
    end
  endfunction

  logic en;

  // stage 1: input register, branch select
  logic        s1_v_r;
  comp_t       s1_x_r, s1_y_r, s1_z_r;
  logic        s1_selx_r;
  logic [15:0] abs_x, abs_y;

  assign abs_x = in_normal_x[15] ? (~in_normal_x + 16'd1) : in_normal_x;
  assign abs_y = in_normal_y[15] ? (~in_normal_y + 16'd1) : in_normal_y;

  // stage 2: squares
  logic               s2_v_r;
  obn_tag_t           s2_tag_r;
  logic signed [31:0] s2_sqa_r, s2_sqz_r;
  comp_t              s1_a;

  assign s1_a = s1_selx_r ? s1_x_r : s1_y_r;

  // stage 3: squared length
  logic               s3_v_r;
  obn_tag_t           s3_tag_r;
  logic [SQ_IN_W-1:0] s3_rad_r;
  logic [31:0]        s_sum;

  assign s_sum = s2_sqa_r + s2_sqz_r;

  // square root
  logic             sq_v;
  logic [LEN_W-1:0] sq_root;
  obn_tag_t         sq_tag;

  // dividend set-up
  logic             dv_v_r;
  obn_tag_t         dv_tag_r;
  logic [DW-1:0]    dv_a_r, dv_b_r;
  logic [LEN_W-1:0] dv_den_r;
  logic [15:0]      mag_a, mag_b;
  logic [DW-1:0]    half_len;

  assign mag_a    = sq_tag.z[15] ? (~sq_tag.z + 16'd1) : sq_tag.z;
  assign mag_b    = sq_tag.sel_x ? (sq_tag.x[15] ? (~sq_tag.x + 16'd1) : sq_tag.x)
                                 : (sq_tag.y[15] ? (~sq_tag.y + 16'd1) : sq_tag.y);
  assign half_len = DW'(sq_root >> 1);

  // divider
  logic          dq_v;
  logic [QW-1:0] dq_a, dq_b;
  obn_tag_t      dq_tag;

  // tangent
  logic     tn_v_r;
  obn_tag_t tn_tag_r;
  comp_t    tn_tx_r, tn_ty_r, tn_tz_r;
  comp_t    ta, tb;
  logic     neg_a, neg_b;

  assign neg_a = dq_tag.sel_x ? (!dq_tag.z[15] && (dq_tag.z != '0)) : dq_tag.z[15];
  assign neg_b = dq_tag.sel_x ? dq_tag.x[15] : (!dq_tag.y[15] && (dq_tag.y != '0));
  assign ta    = dq_tag.degen ? '0 : tan_sat(neg_a, 32'(dq_a));
  assign tb    = dq_tag.degen ? '0 : tan_sat(neg_b, 32'(dq_b));

  // cross products
  logic               pr_v_r;
  logic               pr_degen_r;
  comp_t              pr_tx_r, pr_ty_r, pr_tz_r;
  logic signed [31:0] p_ytz_r, p_zty_r, p_ztx_r, p_xtz_r, p_xty_r, p_ytx_r;

  // differences
  logic               df_v_r;
  logic               df_degen_r;
  comp_t              df_tx_r, df_ty_r, df_tz_r;
  logic signed [32:0] df_bx_r, df_by_r, df_bz_r;

  // rounding
  logic rr_v_r;
  res_t rr_d_r;

  // output buffer
  logic out_v_r, out_v_nxt;
  logic spare_v_r, spare_v_nxt;
  res_t out_d_r, out_d_nxt;
  res_t spare_d_r, spare_d_nxt;

  assign en       = !spare_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      dv_v_r <= 1'b0;
      tn_v_r <= 1'b0;
      pr_v_r <= 1'b0;
      df_v_r <= 1'b0;
      rr_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      dv_v_r <= sq_v;
      tn_v_r <= dq_v;
      pr_v_r <= tn_v_r;
      df_v_r <= pr_v_r;
      rr_v_r <= df_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r    <= in_normal_x;
      s1_y_r    <= in_normal_y;
      s1_z_r    <= in_normal_z;
      s1_selx_r <= (abs_x > abs_y);

      s2_sqa_r       <= s1_a * s1_a;
      s2_sqz_r       <= s1_z_r * s1_z_r;
      s2_tag_r.x     <= s1_x_r;
      s2_tag_r.y     <= s1_y_r;
      s2_tag_r.z     <= s1_z_r;
      s2_tag_r.sel_x <= s1_selx_r;
      s2_tag_r.degen <= (s1_a == '0) && (s1_z_r == '0);

      s3_rad_r       <= {s_sum, 16'h0000};
      s3_tag_r       <= s2_tag_r;

      dv_a_r   <= (DW'(mag_a) << (FRAC_BITS + EXTRA_BITS)) + half_len;
      dv_b_r   <= (DW'(mag_b) << (FRAC_BITS + EXTRA_BITS)) + half_len;
      dv_den_r <= sq_root;
      dv_tag_r <= sq_tag;

      tn_tag_r <= dq_tag;
      tn_tx_r  <= dq_tag.sel_x ? ta : '0;
      tn_ty_r  <= dq_tag.sel_x ? '0 : ta;
      tn_tz_r  <= tb;

      pr_degen_r <= tn_tag_r.degen;
      pr_tx_r    <= tn_tx_r;
      pr_ty_r    <= tn_ty_r;
      pr_tz_r    <= tn_tz_r;
      p_ytz_r    <= tn_tag_r.y * tn_tz_r;
      p_zty_r    <= tn_tag_r.z * tn_ty_r;
      p_ztx_r    <= tn_tag_r.z * tn_tx_r;
      p_xtz_r    <= tn_tag_r.x * tn_tz_r;
      p_xty_r    <= tn_tag_r.x * tn_ty_r;
      p_ytx_r    <= tn_tag_r.y * tn_tx_r;

      df_degen_r <= pr_degen_r;
      df_tx_r    <= pr_tx_r;
      df_ty_r    <= pr_ty_r;
      df_tz_r    <= pr_tz_r;
      df_bx_r    <= 33'(p_ytz_r) - 33'(p_zty_r);
      df_by_r    <= 33'(p_ztx_r) - 33'(p_xtz_r);
      df_bz_r    <= 33'(p_xty_r) - 33'(p_ytx_r);

      rr_d_r.tx    <= df_tx_r;
      rr_d_r.ty    <= df_ty_r;
      rr_d_r.tz    <= df_tz_r;
      rr_d_r.bx    <= rnd_sat(df_bx_r);
      rr_d_r.by    <= rnd_sat(df_by_r);
      rr_d_r.bz    <= rnd_sat(df_bz_r);
      rr_d_r.degen <= df_degen_r;
    end
  end

  obn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_rad    (s3_rad_r),
    .in_tag    (s3_tag_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  obn_div #(
    .QW (QW),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_v_r),
    .in_num_a  (dv_a_r),
    .in_num_b  (dv_b_r),
    .in_den    (dv_den_r),
    .in_tag    (dv_tag_r),
    .out_valid (dq_v),
    .out_quo_a (dq_a),
    .out_quo_b (dq_b),
    .out_tag   (dq_tag)
  );

  always_comb begin
    out_v_nxt   = out_v_r;
    out_d_nxt   = out_d_r;
    spare_v_nxt = spare_v_r;
    spare_d_nxt = spare_d_r;
    if (out_v_r && out_ready) begin
      if (spare_v_r) begin
        out_d_nxt   = spare_d_r;
        spare_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
    if (en && rr_v_r) begin
      if (!out_v_r || out_ready) begin
        out_v_nxt = 1'b1;
        out_d_nxt = rr_d_r;
      end else begin
        spare_v_nxt = 1'b1;
        spare_d_nxt = rr_d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      out_v_r   <= out_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r   <= out_d_nxt;
    spare_d_r <= spare_d_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_tangent_x   = out_d_r.tx;
  assign out_tangent_y   = out_d_r.ty;
  assign out_tangent_z   = out_d_r.tz;
  assign out_bitangent_x = out_d_r.bx;
  assign out_bitangent_y = out_d_r.by;
  assign out_bitangent_z = out_d_r.bz;
  assign out_degenerate  = out_d_r.degen;

`ifndef SYNTHESIS
  a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> out_v_r)
    else $error("buffered item without a pending output");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.degen) |-> (out_d_r.tx == '0 && out_d_r.ty == '0 &&
      out_d_r.tz == '0 && out_d_r.bx == '0 && out_d_r.by == '0 && out_d_r.bz == '0))
    else $error("degenerate item with nonzero vectors");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(rr_v_r) && $stable(s1_v_r)))
    else $error("pipeline moved during stall");

  a_spare_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (rr_v_r && en && out_v_r && !out_ready) |=> spare_v_r)
    else $error("item dropped at output buffer");
`endif

endmodule

// File: verif/obn_checker.sv
// Checker for the orthonormal basis block: predicts each frame and compares results.
module obn_checker #(
  parameter int FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  obn_pkg::comp_t in_normal_x,
  input  obn_pkg::comp_t in_normal_y,
  input  obn_pkg::comp_t in_normal_z,
  input  logic           out_valid,
  input  logic           out_ready,
  input  obn_pkg::comp_t out_tangent_x,
  input  obn_pkg::comp_t out_tangent_y,
  input  obn_pkg::comp_t out_tangent_z,
  input  obn_pkg::comp_t out_bitangent_x,
  input  obn_pkg::comp_t out_bitangent_y,
  input  obn_pkg::comp_t out_bitangent_z,
  input  logic           out_degenerate,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import obn_pkg::*;

  typedef struct packed {
    comp_t tx, ty, tz, bx, by, bz;
    logic  degen;
  } frame_t;

  frame_t frames_due[$];

  assign pending = frames_due.size();

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(longint num, longint unsigned len);
    longint unsigned m, q;
    m = (num < 0 ? -num : num);
    m = m << (FRAC_BITS + EXTRA_BITS);
    q = (m + (len >> 1)) / len;
    if (q > 65536) q = 65536;
    return sat16(num < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint round_shift(longint v);
    longint unsigned m, q;
    m = (v < 0 ? -v : v);
    q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (q > 65536) q = 65536;
    return sat16(v < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic frame_t build_frame(comp_t nx, comp_t ny, comp_t nz);
    longint x, y, z, tx, ty, tz, ax, ay;
    longint unsigned len;
    frame_t f;
    x = nx; y = ny; z = nz;
    tx = 0; ty = 0; tz = 0;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    f.degen = 1'b0;
    if (ax > ay) begin
      len = root_floor(longint'(x * x + z * z) << 16);
      if (len == 0) f.degen = 1'b1;
      else begin
        tx = unit_comp(-z, len);
        tz = unit_comp(x, len);
      end
    end else begin
      len = root_floor(longint'(y * y + z * z) << 16);
      if (len == 0) f.degen = 1'b1;
      else begin
        ty = unit_comp(z, len);
        tz = unit_comp(-y, len);
      end
    end
    f.tx = comp_t'(tx);
    f.ty = comp_t'(ty);
    f.tz = comp_t'(tz);
    f.bx = comp_t'(round_shift(y * tz - z * ty));
    f.by = comp_t'(round_shift(z * tx - x * tz));
    f.bz = comp_t'(round_shift(x * ty - y * tx));
    return f;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    frame_t w;
    if (rst_n) begin
      if (in_valid && in_ready)
        frames_due.push_back(build_frame(in_normal_x, in_normal_y, in_normal_z));
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report("result items outstanding", 1, 0);
        end else begin
          w = frames_due.pop_front();
          if (out_tangent_x !== w.tx) report("tangent_x", out_tangent_x, w.tx);
          if (out_tangent_y !== w.ty) report("tangent_y", out_tangent_y, w.ty);
          if (out_tangent_z !== w.tz) report("tangent_z", out_tangent_z, w.tz);
          if (out_bitangent_x !== w.bx) report("bitangent_x", out_bitangent_x, w.bx);
          if (out_bitangent_y !== w.by) report("bitangent_y", out_bitangent_y, w.by);
          if (out_bitangent_z !== w.bz) report("bitangent_z", out_bitangent_z, w.bz);
          if (out_degenerate !== w.degen) report("degenerate", out_degenerate, w.degen);
        end
      end
    end
  end
endmodule

// File: verif/tb.sv
// Top of the orthonormal basis testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obn_pkg::*;

  localparam int FRAC_BITS = 14;
  localparam int LATENCY = FRAC_BITS + 35;
  localparam int NUM_RANDOM = 1250;
  localparam longint CYCLE_LIMIT = 400000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  comp_t in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  comp_t out_tangent_x, out_tangent_y, out_tangent_z;
  comp_t out_bitangent_x, out_bitangent_y, out_bitangent_z;
  logic  out_degenerate;
  int    errors, pending;
  longint cycles = 0;
  bit    calm = 1'b0;
  bit    hold_off = 1'b0;

  orthonormal_basis_from_normal_unit #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  obn_checker #(.FRAC_BITS(FRAC_BITS)) chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 34);
  end

  task automatic send(comp_t x, comp_t y, comp_t z);
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_normal_x <= x;
    in_normal_y <= y;
    in_normal_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic comp_t pick_comp();
    case ($urandom_range(5))
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(32) - 16);
      2: return $urandom_range(1) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
      default: return comp_t'($urandom_range(32768) - 16384);
    endcase
  endfunction

  initial begin
    comp_t edge_vals[7] = '{16'sh0000, 16'sh0001, 16'shffff, 16'sh4000, 16'shc000,
                           16'sh7fff, 16'sh8000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(16'sh0000, 16'sh0000, 16'sh0000);
    send(16'sh0000, 16'sh0000, 16'sh4000);
    send(16'sh4000, 16'sh4000, 16'sh0000);
    send(16'shc000, 16'sh4000, 16'sh0001);
    send(16'sh4000, 16'sh0000, 16'sh0000);
    send(16'sh0000, 16'shc000, 16'sh0000);
    send(16'sh7fff, 16'sh8000, 16'sh7fff);
    send(16'sh8000, 16'sh7fff, 16'sh8000);
    send(16'sh8000, 16'sh8000, 16'sh8000);
    send(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(16'sh0001, 16'sh0000, 16'sh0000);
    send(16'sh0000, 16'shffff, 16'sh0000);
    send(16'sh2d41, 16'sh2d41, 16'sh0000);
    for (int i = 0; i < 10; i++)
      send(edge_vals[$urandom_range(6)], edge_vals[$urandom_range(6)],
           edge_vals[$urandom_range(6)]);
    hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 120; i++) send(pick_comp(), pick_comp(), pick_comp());
    join
    for (int i = 0; i < NUM_RANDOM - 120; i++) begin
      if (i == 300) calm <= 1'b1;
      if (i == 500) calm <= 1'b0;
      send(pick_comp(), pick_comp(), pick_comp());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/obn_pkg.sv
design/obn_sqrt.sv
design/obn_div.sv
design/orthonormal_basis_from_normal_unit.sv
verif/obn_checker.sv
verif/tb.sv
